// ===== design/psl_pkg.sv =====
// Shared types and constants for the per-source connection limiter.
// Holds table geometry, status and state codes, and the structs passed between modules.
// No dependencies.
package psl_pkg;

    // Table size must be a power of two: the home slot is the low address bits.
    localparam int TABLE_SLOTS = 256;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int STEP_W      = SLOT_W + 1;
    localparam int DISTINCT_W  = SLOT_W + 1;
    localparam int ADDR_W      = 32;
    localparam int COUNT_W     = 16;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic {
        ACT_ADD,
        ACT_REMOVE
    } action_t;

    typedef enum logic [2:0] {
        STAT_OK,
        STAT_TOTAL_LIMIT,
        STAT_SOURCE_LIMIT,
        STAT_PER_SOURCE_LIMIT,
        STAT_TABLE_FULL,
        STAT_NOT_FOUND
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIMIT_TOTAL,
        REG_LIMIT_SOURCES,
        REG_LIMIT_PER_SOURCE
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_MATCH,
        S_DECIDE,
        S_SHIFT_RD,
        S_SHIFT_CHK,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        PR_FREE,
        PR_HIT,
        PR_NONE
    } probe_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] count;
    } slot_entry_t;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        slot_entry_t       wdata;
        logic              re;
        logic [SLOT_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        logic [COUNT_W-1:0] total;
        logic [COUNT_W-1:0] sources;
        logic [COUNT_W-1:0] per_source;
    } limits_t;

    typedef struct packed {
        status_t               status;
        logic [COUNT_W-1:0]    source_count;
        logic [COUNT_W-1:0]    total_count;
        logic [DISTINCT_W-1:0] distinct_count;
    } result_t;

endpackage

// ===== design/psl_slot_ram.sv =====
// Slot store: address and count of every table slot, one write and one read port.
// Read data is registered. Depends on psl_pkg.
module psl_slot_ram
    import psl_pkg::*;
(
    input  logic        clk,
    input  ram_req_t    req,
    output slot_entry_t rd_data
);

    slot_entry_t mem [TABLE_SLOTS];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data <= mem[req.raddr];
        end
    end

endmodule

// ===== design/psl_ctrl.sv =====
// Request sequencer: probes the slot store, applies the limits, updates counters,
// and closes freed slots by backward shift. Holds the slot valid bits. Depends on psl_pkg.
module psl_ctrl
    import psl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  limits_t           limits,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              action,
    input  logic [ADDR_W-1:0] src_addr,
    output ram_req_t          ram_req,
    input  slot_entry_t       ram_rd,
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           res
);

    state_t                 state_reg,   state_next;
    action_t                act_reg,     act_next;
    logic [ADDR_W-1:0]      key_reg,     key_next;
    logic [SLOT_W-1:0]      idx_reg,     idx_next;
    logic [SLOT_W-1:0]      hole_reg,    hole_next;
    logic [STEP_W-1:0]      step_reg,    step_next;
    probe_t                 probe_reg,   probe_next;
    logic [COUNT_W-1:0]     cnt_reg,     cnt_next;
    logic [COUNT_W-1:0]     total_reg,   total_next;
    logic [DISTINCT_W-1:0]  sources_reg, sources_next;
    logic [TABLE_SLOTS-1:0] used_reg,    used_next;
    result_t                res_reg,     res_next;

    logic               disabled;
    logic               hit;
    logic               walk_end;
    logic               frees_slot;
    logic [COUNT_W-1:0] dec_count;
    logic [SLOT_W-1:0]  home;
    logic [SLOT_W-1:0]  dist_home;
    logic [SLOT_W-1:0]  dist_hole;

    assign disabled   = (limits.total == '0) && (limits.sources == '0)
                        && (limits.per_source == '0);
    assign hit        = (ram_rd.addr == key_reg);
    assign walk_end   = (step_reg == STEP_W'(TABLE_SLOTS));
    assign dec_count  = (cnt_reg != '0) ? cnt_reg - COUNT_W'(1) : '0;
    assign frees_slot = (act_reg == ACT_REMOVE) && (probe_reg == PR_HIT)
                        && (dec_count == '0);
    assign home       = ram_rd.addr[SLOT_W-1:0];
    assign dist_home  = idx_reg - home;
    assign dist_hole  = idx_reg - hole_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = disabled ? S_FINISH : S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (walk_end || !used_reg[idx_reg])
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                state_next = hit ? S_DECIDE : S_PROBE;
            end
            S_DECIDE:
            begin
                state_next = frees_slot ? S_SHIFT_RD : S_FINISH;
            end
            S_SHIFT_RD:
            begin
                if (walk_end || !used_reg[idx_reg])
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_SHIFT_CHK;
                end
            end
            S_SHIFT_CHK:
            begin
                state_next = S_SHIFT_RD;
            end
            S_FINISH:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready  = (state_reg == S_IDLE);
        res_valid = (state_reg == S_FINISH);
        res       = res_reg;
        ram_req   = '0;
        unique case (state_reg)
            S_PROBE:
            begin
                ram_req.re    = !walk_end && used_reg[idx_reg];
                ram_req.raddr = idx_reg;
            end
            S_DECIDE:
            begin
                ram_req.waddr      = idx_reg;
                ram_req.wdata.addr = key_reg;
                if (act_reg == ACT_ADD)
                begin
                    if (!((limits.total != '0 && total_reg >= limits.total)
                          || total_reg == '1))
                    begin
                        if (probe_reg == PR_HIT)
                        begin
                            ram_req.we = !((limits.per_source != '0
                                            && cnt_reg >= limits.per_source)
                                           || cnt_reg == '1);
                            ram_req.wdata.count = cnt_reg + COUNT_W'(1);
                        end
                        else if (probe_reg == PR_FREE)
                        begin
                            ram_req.we = !(limits.sources != '0
                                           && COUNT_W'(sources_reg) >= limits.sources);
                            ram_req.wdata.count = COUNT_W'(1);
                        end
                    end
                end
                else
                begin
                    ram_req.we          = (probe_reg == PR_HIT);
                    ram_req.wdata.count = dec_count;
                end
            end
            S_SHIFT_RD:
            begin
                ram_req.re    = !walk_end && used_reg[idx_reg];
                ram_req.raddr = idx_reg;
            end
            S_SHIFT_CHK:
            begin
                // move the entry back into the hole unless that would cross its home
                ram_req.we    = (dist_home >= dist_hole);
                ram_req.waddr = hole_reg;
                ram_req.wdata = ram_rd;
            end
            default:
            begin
            end
        endcase
    end

    // datapath
    always_comb
    begin
        act_next     = act_reg;
        key_next     = key_reg;
        idx_next     = idx_reg;
        hole_next    = hole_reg;
        step_next    = step_reg;
        probe_next   = probe_reg;
        cnt_next     = cnt_reg;
        total_next   = total_reg;
        sources_next = sources_reg;
        used_next    = used_reg;
        res_next     = res_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next  = action_t'(action);
                    key_next  = src_addr;
                    idx_next  = src_addr[SLOT_W-1:0];
                    step_next = '0;
                    res_next  = '{status: STAT_OK, source_count: '0,
                                  total_count: total_reg, distinct_count: sources_reg};
                end
            end
            S_PROBE:
            begin
                if (walk_end)
                begin
                    probe_next = PR_NONE;
                end
                else if (!used_reg[idx_reg])
                begin
                    probe_next = PR_FREE;
                end
            end
            S_MATCH:
            begin
                if (hit)
                begin
                    probe_next = PR_HIT;
                    cnt_next   = ram_rd.count;
                end
                else
                begin
                    idx_next  = idx_reg + SLOT_W'(1);
                    step_next = step_reg + STEP_W'(1);
                end
            end
            S_DECIDE:
            begin
                res_next.status       = STAT_OK;
                res_next.source_count = (probe_reg == PR_HIT) ? cnt_reg : '0;
                if (act_reg == ACT_ADD)
                begin
                    if ((limits.total != '0 && total_reg >= limits.total)
                        || total_reg == '1)
                    begin
                        res_next.status = STAT_TOTAL_LIMIT;
                    end
                    else if (probe_reg == PR_HIT)
                    begin
                        if ((limits.per_source != '0 && cnt_reg >= limits.per_source)
                            || cnt_reg == '1)
                        begin
                            res_next.status = STAT_PER_SOURCE_LIMIT;
                        end
                        else
                        begin
                            res_next.source_count = cnt_reg + COUNT_W'(1);
                            total_next            = total_reg + COUNT_W'(1);
                        end
                    end
                    else if (probe_reg == PR_FREE)
                    begin
                        if (limits.sources != '0 && COUNT_W'(sources_reg) >= limits.sources)
                        begin
                            res_next.status = STAT_SOURCE_LIMIT;
                        end
                        else
                        begin
                            used_next[idx_reg]    = 1'b1;
                            res_next.source_count = COUNT_W'(1);
                            sources_next          = sources_reg + DISTINCT_W'(1);
                            total_next            = total_reg + COUNT_W'(1);
                        end
                    end
                    else
                    begin
                        res_next.status = STAT_TABLE_FULL;
                    end
                end
                else if (probe_reg != PR_HIT)
                begin
                    res_next.status = STAT_NOT_FOUND;
                end
                else
                begin
                    res_next.source_count = dec_count;
                    if (total_reg != '0)
                    begin
                        total_next = total_reg - COUNT_W'(1);
                    end
                    if (dec_count == '0)
                    begin
                        // free the slot and start the backward-shift walk after it
                        used_next[idx_reg] = 1'b0;
                        if (sources_reg != '0)
                        begin
                            sources_next = sources_reg - DISTINCT_W'(1);
                        end
                        hole_next = idx_reg;
                        idx_next  = idx_reg + SLOT_W'(1);
                        step_next = STEP_W'(1);
                    end
                end
                res_next.total_count    = total_next;
                res_next.distinct_count = sources_next;
            end
            S_SHIFT_CHK:
            begin
                if (dist_home >= dist_hole)
                begin
                    used_next[hole_reg] = 1'b1;
                    used_next[idx_reg]  = 1'b0;
                    hole_next           = idx_reg;
                end
                idx_next  = idx_reg + SLOT_W'(1);
                step_next = step_reg + STEP_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            total_reg   <= '0;
            sources_reg <= '0;
            used_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            sources_reg <= sources_next;
            used_reg    <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        key_reg   <= key_next;
        idx_reg   <= idx_next;
        hole_reg  <= hole_next;
        step_reg  <= step_next;
        probe_reg <= probe_next;
        cnt_reg   <= cnt_next;
        res_reg   <= res_next;
    end

endmodule

// ===== design/per_source_connection_limiter.sv =====
// Per-source connection limiter, top level: limit registers, output register,
// sequencer and slot store. Depends on psl_pkg, psl_ctrl and psl_slot_ram.
//
// Usage: a request (action, src_addr) transfers on in_valid/in_ready; one result
// (status, source_count, total_count, distinct_count) transfers per request on
// out_valid/out_ready. Limits are written through cfg_we/cfg_index/cfg_data while
// no request is in flight; unknown indexes are ignored.
// One request is worked at a time. After accept, the probe walk reads and checks
// one occupied slot after another (each compare is one store read plus one check)
// until it ends on a free slot, on the matching entry or after the whole table;
// the limits are then applied. A remove that frees its slot then runs the
// backward shift, reading and checking each occupied slot after it in the
// cluster. With all limits zero the result shows without any probe.
// The result sits in an output register: the next request is taken and worked
// while it waits, and only the hand-off of the following result stalls on out_ready.
// Reset clears limits, counters and the slot valid bits at once; the store
// contents need no clearing pass and requests are taken in the first cycle.
module per_source_connection_limiter
    import psl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [COUNT_W-1:0]    cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  action,
    input  logic [ADDR_W-1:0]     src_addr,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [2:0]            status,
    output logic [COUNT_W-1:0]    source_count,
    output logic [COUNT_W-1:0]    total_count,
    output logic [DISTINCT_W-1:0] distinct_count
);

    limits_t     limits_reg, limits_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg;
    ram_req_t    ram_req;
    slot_entry_t ram_rd;
    logic        res_valid;
    logic        res_ready;
    result_t     res;

    always_comb
    begin
        limits_next = limits_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LIMIT_TOTAL:      limits_next.total      = cfg_data;
                REG_LIMIT_SOURCES:    limits_next.sources    = cfg_data;
                REG_LIMIT_PER_SOURCE: limits_next.per_source = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            limits_reg    <= limits_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the result until it transfers
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_reg.status;
    assign source_count   = out_reg.source_count;
    assign total_count    = out_reg.total_count;
    assign distinct_count = out_reg.distinct_count;

    psl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .limits    (limits_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .src_addr  (src_addr),
        .ram_req   (ram_req),
        .ram_rd    (ram_rd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    psl_slot_ram u_slot_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (ram_rd)
    );

endmodule
